// ----- hdl/lspe_pkg.sv -----
// Shared widths, register codes and the channel weight function of the line sensor estimator.
`timescale 1ns / 1ps

package lspe_pkg;

   // field widths
   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 16;
   localparam int NORM_W   = 10;
   localparam int POS_W    = 13;
   localparam int SUM_W    = 13;
   localparam int WSUM_W   = 25;
   localparam int CAL_W    = 64;
   localparam int WEIGHT_W = 13;
   localparam int PROD_W   = NORM_W + WEIGHT_W;

   // divider datapath: numerator (raw - min) * 1000 fits in 26 bits
   localparam int DIV_W   = 26;
   localparam int QUO_W   = 13;
   localparam int CNT_W   = 4;
   localparam int NORM_QB = 10;   // quotient bits for the sample normalization
   localparam int POS_QB  = 13;   // quotient bits for the centroid

   localparam int NUM_CHANNELS_DEFAULT = 8;

   localparam logic [NORM_W-1:0] NORM_FULL = 10'd1000;
   localparam logic [SUM_W-1:0]  SUM_MAX   = 13'd8191;
   localparam logic [WSUM_W-1:0] WSUM_MAX  = 25'd33554431;

   // configuration register codes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_MIN_LOW  = 3'd0,
      CSR_CAL_MIN_HIGH = 3'd1,
      CSR_CAL_MAX_LOW  = 3'd2,
      CSR_CAL_MAX_HIGH = 3'd3,
      CSR_LINE_THRESH  = 3'd4
   } csr_index_type;

   // position weight of a channel: channel * 1000
   function automatic logic [WEIGHT_W-1:0] chan_weight(input logic [CH_W-1:0] ch);
      return WEIGHT_W'(ch) * WEIGHT_W'(NORM_FULL);
   endfunction

endpackage

// ----- hdl/line_sensor_position_estimator.sv -----
// Line sensor position estimator: sample normalization and weighted centroid per frame.
`timescale 1ns / 1ps

// One word per sample in, one word per sample out. A sample is scaled to 0..1000 with its
// channel's calibration window by a shift-subtract divider that resolves one quotient bit a
// cycle. The last channel (NUM_CHANNELS-1) then runs the same divider over the frame's
// weighted sum for up to 13 more bits. The block works on one word at a time; its result
// sits in an output register, so the next word is taken while the previous result still
// waits. Configuration writes are always ready and must be made while no word is in flight.
module line_sensor_position_estimator #(
   parameter int NUM_CHANNELS = lspe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lspe_pkg::CH_W-1:0]      req_sensor_channel,
   input  logic [lspe_pkg::SAMPLE_W-1:0]  req_raw_sample,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lspe_pkg::CH_W-1:0]      rsp_out_channel,
   output logic [lspe_pkg::NORM_W-1:0]    rsp_normalized,
   output logic                           rsp_frame_end,
   output logic [lspe_pkg::POS_W-1:0]     rsp_line_position,
   output logic                           rsp_signal_seen,
   output logic                           rsp_on_line,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lspe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lspe_pkg::CAL_W-1:0]     csr_wdata
);
   import lspe_pkg::*;

   localparam logic [CH_W:0]    NUM_CH   = (CH_W + 1)'(NUM_CHANNELS);
   localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(NUM_CHANNELS - 1);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'((NUM_CHANNELS - 1) * 1000);
   localparam logic [CAL_W-1:0] MAX_INIT = 64'h0001_0001_0001_0001;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_NCHK,
      S_NDIV,
      S_ACC,
      S_WACC,
      S_PCHK,
      S_PDIV,
      S_DONE
   } state_type;

   // control and architectural state
   state_type             state_ff, state_in;
   logic [CAL_W-1:0]      cal_min_lo_ff, cal_min_lo_in;
   logic [CAL_W-1:0]      cal_min_hi_ff, cal_min_hi_in;
   logic [CAL_W-1:0]      cal_max_lo_ff, cal_max_lo_in;
   logic [CAL_W-1:0]      cal_max_hi_ff, cal_max_hi_in;
   logic [NORM_W-1:0]     thresh_ff, thresh_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [WSUM_W-1:0]     wsum_ff, wsum_in;
   logic [NORM_W-1:0]     peak_ff, peak_in;
   logic [POS_W-1:0]      held_ff, held_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]       rsp_ch_ff, rsp_ch_in;
   logic [NORM_W-1:0]     rsp_norm_ff, rsp_norm_in;
   logic                  rsp_end_ff, rsp_end_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  rsp_seen_ff, rsp_seen_in;
   logic                  rsp_online_ff, rsp_online_in;

   // datapath registers
   logic [CH_W-1:0]       item_ch_ff, item_ch_in;
   logic [SAMPLE_W-1:0]   diff_ff, diff_in;
   logic [SAMPLE_W-1:0]   divisor_ff, divisor_in;
   logic                  below_ff, below_in;
   logic [DIV_W-1:0]      div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]      div_sub_ff, div_sub_in;
   logic [QUO_W-1:0]      div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [NORM_W-1:0]     norm_ff, norm_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  seen_ff, seen_in;
   logic                  online_ff, online_in;

   // calibration word lookup for the incoming channel
   logic [CAL_W-1:0]      min_reg, max_reg;
   logic [SAMPLE_W-1:0]   cal_min, cal_max;
   logic [CH_W:0]         ch_ext;
   logic                  item_in_array, item_last;

   // one shift-subtract step of the divider
   logic                  div_ge;
   logic [DIV_W-1:0]      div_diff;
   logic [QUO_W-1:0]      quo_next;

   // accumulation terms
   logic [SUM_W:0]        sum_add;
   logic [WSUM_W:0]       wsum_add;
   logic [SUM_W-1:0]      sum_base;
   logic [NORM_W-1:0]     peak_base;

   logic                  out_free;

   assign min_reg = req_sensor_channel[2] ? cal_min_hi_ff : cal_min_lo_ff;
   assign max_reg = req_sensor_channel[2] ? cal_max_hi_ff : cal_max_lo_ff;
   assign cal_min = min_reg[{req_sensor_channel[1:0], 4'b0000} +: SAMPLE_W];
   assign cal_max = max_reg[{req_sensor_channel[1:0], 4'b0000} +: SAMPLE_W];

   assign ch_ext        = {1'b0, item_ch_ff};
   assign item_in_array = ch_ext < NUM_CH;
   assign item_last     = item_in_array && (item_ch_ff == LAST_CH);

   assign div_ge   = div_rem_ff >= div_sub_ff;
   assign div_diff = div_rem_ff - div_sub_ff;
   assign quo_next = {div_quo_ff[QUO_W-2:0], div_ge};

   // channel 0 opens a fresh frame
   assign sum_base  = (item_ch_ff == '0) ? '0 : sum_ff;
   assign peak_base = (item_ch_ff == '0) ? '0 : peak_ff;
   assign sum_add   = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(norm_ff);
   assign wsum_add  = (WSUM_W + 1)'(wsum_ff) + (WSUM_W + 1)'(prod_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall         = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_normalized    = rsp_norm_ff;
   assign rsp_frame_end     = rsp_end_ff;
   assign rsp_line_position = rsp_pos_ff;
   assign rsp_signal_seen   = rsp_seen_ff;
   assign rsp_on_line       = rsp_online_ff;

   always_comb begin
      state_in      = state_ff;
      cal_min_lo_in = cal_min_lo_ff;
      cal_min_hi_in = cal_min_hi_ff;
      cal_max_lo_in = cal_max_lo_ff;
      cal_max_hi_in = cal_max_hi_ff;
      thresh_in     = thresh_ff;
      sum_in        = sum_ff;
      wsum_in       = wsum_ff;
      peak_in       = peak_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ch_in     = rsp_ch_ff;
      rsp_norm_in   = rsp_norm_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_online_in = rsp_online_ff;
      item_ch_in    = item_ch_ff;
      diff_in       = diff_ff;
      divisor_in    = divisor_ff;
      below_in      = below_ff;
      div_rem_in    = div_rem_ff;
      div_sub_in    = div_sub_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      norm_in       = norm_ff;
      prod_in       = prod_ff;
      seen_in       = seen_ff;
      online_in     = online_ff;

      // take register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_MIN_LOW:  cal_min_lo_in = csr_wdata;
            CSR_CAL_MIN_HIGH: cal_min_hi_in = csr_wdata;
            CSR_CAL_MAX_LOW:  cal_max_lo_in = csr_wdata;
            CSR_CAL_MAX_HIGH: cal_max_hi_in = csr_wdata;
            CSR_LINE_THRESH:  thresh_in     = csr_wdata[NORM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // latch the word and its calibration window
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               item_ch_in = req_sensor_channel;
               below_in   = req_raw_sample <= cal_min;
               diff_in    = req_raw_sample - cal_min;
               divisor_in = (cal_max > cal_min) ? (cal_max - cal_min) : SAMPLE_W'(1);
               state_in   = S_MUL;
            end
         end
         // scale the offset by full range
         S_MUL: begin
            div_rem_in = DIV_W'(diff_ff) * DIV_W'(NORM_FULL);
            div_sub_in = {divisor_ff, NORM_QB'(0)};
            state_in   = S_NCHK;
         end
         // settle the zero and saturated cases, else start the divider
         S_NCHK: begin
            if (below_ff) begin
               norm_in  = '0;
               state_in = S_ACC;
            end else if (div_ge) begin
               norm_in  = NORM_FULL;
               state_in = S_ACC;
            end else begin
               div_sub_in = div_sub_ff >> 1;
               div_quo_in = '0;
               div_cnt_in = CNT_W'(NORM_QB - 1);
               state_in   = S_NDIV;
            end
         end
         // one quotient bit per cycle
         S_NDIV: begin
            if (div_ge) begin
               div_rem_in = div_diff;
            end
            div_quo_in = quo_next;
            div_sub_in = div_sub_ff >> 1;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               norm_in  = (quo_next[NORM_W-1:0] > NORM_FULL) ? NORM_FULL
                                                             : quo_next[NORM_W-1:0];
               state_in = S_ACC;
            end
         end
         // add to the frame sum and peak, form the weighted term; channels in the array only
         S_ACC: begin
            if (item_in_array) begin
               sum_in   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
               peak_in  = (norm_ff > peak_base) ? norm_ff : peak_base;
               prod_in  = PROD_W'(norm_ff) * PROD_W'(chan_weight(item_ch_ff));
               state_in = S_WACC;
               if (item_ch_ff == '0) begin
                  wsum_in = '0;
               end
            end else begin
               seen_in   = 1'b0;
               online_in = 1'b0;
               state_in  = S_DONE;
            end
         end
         // add the weighted term; the last channel goes on to the centroid
         S_WACC: begin
            wsum_in = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
            seen_in   = 1'b0;
            online_in = 1'b0;
            if (item_last) begin
               div_rem_in = DIV_W'(wsum_in);
               div_sub_in = {sum_ff, POS_QB'(0)};
               state_in   = S_PCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         // hold on an empty frame, clamp on overflow, else divide
         S_PCHK: begin
            online_in = peak_ff > thresh_ff;
            if (sum_ff == '0) begin
               state_in = S_DONE;
            end else if (div_ge) begin
               held_in  = POS_MAX;
               seen_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               div_sub_in = div_sub_ff >> 1;
               div_quo_in = '0;
               div_cnt_in = CNT_W'(POS_QB - 1);
               state_in   = S_PDIV;
            end
         end
         S_PDIV: begin
            if (div_ge) begin
               div_rem_in = div_diff;
            end
            div_quo_in = quo_next;
            div_sub_in = div_sub_ff >> 1;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               held_in  = (quo_next > POS_MAX) ? POS_MAX : quo_next;
               seen_in  = 1'b1;
               state_in = S_DONE;
            end
         end
         // hand the word to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = item_ch_ff;
               rsp_norm_in   = norm_ff;
               rsp_end_in    = item_last;
               rsp_pos_in    = held_ff;
               rsp_seen_in   = seen_ff;
               rsp_online_in = online_ff;
               if (item_last) begin
                  sum_in  = '0;
                  wsum_in = '0;
                  peak_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, configuration, accumulators and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cal_min_lo_ff <= '0;
         cal_min_hi_ff <= '0;
         cal_max_lo_ff <= MAX_INIT;
         cal_max_hi_ff <= MAX_INIT;
         thresh_ff     <= NORM_W'(500);
         sum_ff        <= '0;
         wsum_ff       <= '0;
         peak_ff       <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_ch_ff     <= '0;
         rsp_norm_ff   <= '0;
         rsp_end_ff    <= 1'b0;
         rsp_pos_ff    <= '0;
         rsp_seen_ff   <= 1'b0;
         rsp_online_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cal_min_lo_ff <= cal_min_lo_in;
         cal_min_hi_ff <= cal_min_hi_in;
         cal_max_lo_ff <= cal_max_lo_in;
         cal_max_hi_ff <= cal_max_hi_in;
         thresh_ff     <= thresh_in;
         sum_ff        <= sum_in;
         wsum_ff       <= wsum_in;
         peak_ff       <= peak_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ch_ff     <= rsp_ch_in;
         rsp_norm_ff   <= rsp_norm_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_seen_ff   <= rsp_seen_in;
         rsp_online_ff <= rsp_online_in;
      end
   end

   // working registers of the current word
   always_ff @(posedge clock) begin
      item_ch_ff <= item_ch_in;
      diff_ff    <= diff_in;
      divisor_ff <= divisor_in;
      below_ff   <= below_in;
      div_rem_ff <= div_rem_in;
      div_sub_ff <= div_sub_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
      norm_ff    <= norm_in;
      prod_ff    <= prod_in;
      seen_ff    <= seen_in;
      online_ff  <= online_in;
   end

endmodule

// ----- verif/testbench.sv -----
// Testbench of the line sensor position estimator: directed and random sample words.
`timescale 1ns / 1ps

module testbench;
   import lspe_pkg::*;

   localparam int LANES   = NUM_CHANNELS_DEFAULT;
   localparam int POS_TOP = (LANES - 1) * 1000;

   typedef struct {
      logic [CH_W-1:0]   out_channel;
      logic [NORM_W-1:0] normalized;
      logic              frame_end;
      logic [POS_W-1:0]  line_position;
      logic              signal_seen;
      logic              on_line;
   } result_word_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CH_W-1:0]      req_sensor_channel;
   logic [SAMPLE_W-1:0]  req_raw_sample;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CH_W-1:0]      rsp_out_channel;
   logic [NORM_W-1:0]    rsp_normalized;
   logic                 rsp_frame_end;
   logic [POS_W-1:0]     rsp_line_position;
   logic                 rsp_signal_seen;
   logic                 rsp_on_line;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAL_W-1:0]     csr_wdata;

   // predictor copy of the registers and the frame accumulators
   logic [63:0]  cal_min_lo = 64'h0;
   logic [63:0]  cal_min_hi = 64'h0;
   logic [63:0]  cal_max_lo = 64'h0001_0001_0001_0001;
   logic [63:0]  cal_max_hi = 64'h0001_0001_0001_0001;
   int unsigned  thresh     = 500;
   int unsigned  acc_sum    = 0;
   int unsigned  acc_wsum   = 0;
   int unsigned  acc_peak   = 0;
   int unsigned  held_pos   = 0;

   // calibration windows that the next settings load will write
   int unsigned  win_min[LANES];
   int unsigned  win_max[LANES];

   result_word_type pending_words[$];
   int unsigned  error_count   = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;

   line_sensor_position_estimator #(.NUM_CHANNELS(LANES)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sensor_channel (req_sensor_channel),
      .req_raw_sample     (req_raw_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_normalized     (rsp_normalized),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_line_position  (rsp_line_position),
      .rsp_signal_seen    (rsp_signal_seen),
      .rsp_on_line        (rsp_on_line),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic int unsigned cal_word(input logic [63:0] lo, input logic [63:0] hi,
                                            input int unsigned ch);
      logic [63:0] bank;
      bank = (ch < 4) ? lo : hi;
      return int'((bank >> ((ch % 4) * 16)) & 64'hFFFF);
   endfunction

   // scale one sample, fold it into the frame and build its result word
   function automatic result_word_type estimate_word(input logic [CH_W-1:0] ch,
                                                     input logic [SAMPLE_W-1:0] raw);
      result_word_type word;
      int unsigned  mn, mx, span, lvl, s, w, p;
      mn   = cal_word(cal_min_lo, cal_min_hi, ch);
      mx   = cal_word(cal_max_lo, cal_max_hi, ch);
      span = (mx > mn) ? (mx - mn) : 1;
      if (raw <= mn) begin
         lvl = 0;
      end else begin
         lvl = ((raw - mn) * 1000) / span;
         if (lvl > 1000) lvl = 1000;
      end
      word.out_channel = ch;
      word.normalized  = NORM_W'(lvl);
      word.frame_end   = 1'b0;
      word.signal_seen = 1'b0;
      word.on_line     = 1'b0;
      if (ch < LANES) begin
         if (ch == 0) begin
            acc_sum  = 0;
            acc_wsum = 0;
            acc_peak = 0;
         end
         s        = acc_sum + lvl;
         acc_sum  = (s > SUM_MAX) ? SUM_MAX : s;
         w        = acc_wsum + lvl * (ch * 1000);
         acc_wsum = (w > WSUM_MAX) ? WSUM_MAX : w;
         if (lvl > acc_peak) acc_peak = lvl;
         // close the frame on the last channel
         if (ch == LANES - 1) begin
            word.frame_end = 1'b1;
            if (acc_sum != 0) begin
               p = acc_wsum / acc_sum;
               held_pos = (p > POS_TOP) ? POS_TOP : p;
               word.signal_seen = 1'b1;
            end
            word.on_line = (acc_peak > thresh);
            acc_sum  = 0;
            acc_wsum = 0;
            acc_peak = 0;
         end
      end
      word.line_position = POS_W'(held_pos);
      return word;
   endfunction

   // compare each accepted result word with the oldest expectation
   always @(negedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected result word on channel %0d", rsp_out_channel));
         end else begin
            want = pending_words.pop_front();
            check_field("out_channel", rsp_out_channel, want.out_channel);
            check_field("normalized", rsp_normalized, want.normalized);
            check_field("frame_end", rsp_frame_end, want.frame_end);
            check_field("line_position", rsp_line_position, want.line_position);
            check_field("signal_seen", rsp_signal_seen, want.signal_seen);
            check_field("on_line", rsp_on_line, want.on_line);
         end
      end
   end

   // offer one sample word, hold it until taken, then predict its result
   task automatic send_sample(input int unsigned ch, input int unsigned raw);
      bit taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sensor_channel <= CH_W'(ch);
      req_raw_sample     <= SAMPLE_W'(raw);
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_words.push_back(estimate_word(CH_W'(ch), SAMPLE_W'(raw)));
   endtask

   // drop valid and wait until every expected word has been taken
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      case (idx)
         CSR_CAL_MIN_LOW:  cal_min_lo = data;
         CSR_CAL_MIN_HIGH: cal_min_hi = data;
         CSR_CAL_MAX_LOW:  cal_max_lo = data;
         CSR_CAL_MAX_HIGH: cal_max_hi = data;
         CSR_LINE_THRESH:  thresh = int'(data[NORM_W-1:0]);
         default: ;
      endcase
   endtask

   // write the window arrays and the threshold word to the registers once idle
   task automatic load_settings(input logic [63:0] thresh_word);
      logic [63:0] min_lo, min_hi, max_lo, max_hi;
      for (int c = 0; c < 4; c++) begin
         min_lo[c*16 +: 16] = win_min[c][15:0];
         min_hi[c*16 +: 16] = win_min[c+4][15:0];
         max_lo[c*16 +: 16] = win_max[c][15:0];
         max_hi[c*16 +: 16] = win_max[c+4][15:0];
      end
      settle();
      write_reg(CSR_CAL_MIN_LOW, min_lo);
      write_reg(CSR_CAL_MIN_HIGH, min_hi);
      write_reg(CSR_CAL_MAX_LOW, max_lo);
      write_reg(CSR_CAL_MAX_HIGH, max_hi);
      write_reg(CSR_LINE_THRESH, thresh_word);
      csr_valid <= 1'b0;
   endtask

   task automatic set_windows(input int unsigned ch, input int unsigned mn, input int unsigned mx);
      win_min[ch] = mn;
      win_max[ch] = mx;
   endtask

   // pick a raw reading, mostly around the channel's calibration window
   function automatic int unsigned pick_raw(input int unsigned ch);
      int lo, hi, pad;
      lo = win_min[ch];
      hi = (win_max[ch] > win_min[ch]) ? win_max[ch] : win_min[ch] + 8;
      case ($urandom_range(7))
         0: return $urandom_range(16'hFFFF);
         1: return win_min[ch];
         2: return win_max[ch];
         default: begin
            pad = (hi - lo) / 8 + 1;
            lo  = (lo - pad < 0) ? 0 : lo - pad;
            hi  = (hi + pad > 65535) ? 65535 : hi + pad;
            return $urandom_range(hi, lo);
         end
      endcase
   endfunction

   // default calibration after reset: any nonzero sample reads full scale
   task automatic test_reset_defaults();
      send_sample(0, 16'hFFFF);
      send_sample(1, 0);
      send_sample(2, 1);
      send_sample(7, 16'hFFFF);
   endtask

   // below, at and above the window, equal and inverted windows, peak equal to threshold
   task automatic test_calibration_windows();
      set_windows(0, 100, 1100);
      set_windows(1, 500, 500);
      set_windows(2, 900, 300);
      set_windows(3, 0, 16'hFFFF);
      set_windows(4, 16'hFFFF, 16'hFFFF);
      set_windows(5, 1000, 3000);
      set_windows(6, 1000, 3000);
      set_windows(7, 0, 2000);
      load_settings(64'd1000);
      send_sample(0, 99);
      send_sample(0, 100);
      send_sample(0, 1100);
      send_sample(0, 16'hFFFF);
      send_sample(1, 501);
      send_sample(2, 901);
      send_sample(3, 32768);
      send_sample(4, 16'hFFFF);
      send_sample(7, 2000);
   endtask

   // frame with no signal keeps the position; a frame without channel 0 starts clean
   task automatic test_empty_frame();
      load_settings(64'd0);
      send_sample(5, 500);
      send_sample(7, 0);
      send_sample(6, 1002);
      send_sample(7, 0);
   endtask

   // repeated channels drive both sums into saturation
   task automatic test_saturation();
      for (int c = 0; c < LANES; c++) set_windows(c, 0, 1);
      load_settings({54'h3F_FFFF_FFFF_FFFF, 10'd1000});
      for (int n = 0; n < 9; n++) send_sample(5 + (n % 2), 16'hFFFF);
      send_sample(7, 16'hFFFF);
   endtask

   // full range, all-bad, and random calibration windows
   task automatic random_settings(input int kind);
      int unsigned span;
      logic [63:0] word;
      for (int c = 0; c < LANES; c++) begin
         case (kind)
            0: set_windows(c, 0, 16'hFFFF);
            1: begin
               if (c % 2) set_windows(c, 16'hFFFF, 16'hFFFF);
               else set_windows(c, 0, 0);
            end
            default: begin
               win_min[c] = $urandom_range(16'hFFFF);
               case ($urandom_range(3))
                  0: span = $urandom_range(40, 1);
                  1: span = $urandom_range(2000, 41);
                  2: span = $urandom_range(65535, 2001);
                  default: span = 0;
               endcase
               if (span == 0) win_max[c] = $urandom_range(win_min[c]);
               else win_max[c] = (win_min[c] + span > 65535) ? 65535 : win_min[c] + span;
            end
         endcase
      end
      case (kind)
         0: word = 64'd0;
         1: word = 64'd1000;
         default: begin
            word = {$urandom, $urandom};
            word[NORM_W-1:0] = NORM_W'($urandom_range(1023));
         end
      endcase
      load_settings(word);
   endtask

   // mostly whole frames, some broken frames and stray words
   task automatic random_frames(input int unsigned count);
      int unsigned sent;
      int unsigned start;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(9))
            0: begin
               send_sample($urandom_range(7), $urandom_range(16'hFFFF));
               sent++;
            end
            1: begin
               start = $urandom_range(LANES - 1);
               for (int c = start; c < LANES; c++) begin
                  if ($urandom_range(3) == 0) continue;
                  send_sample(c, pick_raw(c));
                  sent++;
                  if ($urandom_range(4) == 0) begin
                     send_sample(c, pick_raw(c));
                     sent++;
                  end
               end
            end
            default: begin
               for (int c = 0; c < LANES; c++) begin
                  send_sample(c, pick_raw(c));
                  sent++;
               end
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 37; recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int kind = 0; kind < 4; kind++) begin
            random_settings(kind);
            random_frames(100);
         end
      end
   endtask

   initial begin
      int n;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_sensor_channel <= '0;
      req_raw_sample     <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 74;
      test_reset_defaults();
      test_calibration_windows();
      test_empty_frame();
      test_saturation();
      test_random_traffic();

      // drain the outstanding words, then watch for strays
      req_valid <= 1'b0;
      n = 0;
      while (pending_words.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      if (pending_words.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", pending_words.size()));
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // end a hung run
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
